### rtl/vn2d_pkg.sv
package vn2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int OUT_W         = 24;

    localparam logic [31:0] HASH_MUL_Z  = 32'd57;
    localparam logic [31:0] HASH_MUL_S  = 32'd131;
    localparam logic [31:0] HASH_MUL_A  = 32'd15731;
    localparam logic [31:0] HASH_ADD_B  = 32'd789221;
    localparam logic [31:0] HASH_ADD_C  = 32'd1376312589;

    // Stage registers of one corner hash.
    typedef struct packed {
        logic [31:0] h;
        logic [31:0] hh;
    } t_hash_s1;

endpackage

### rtl/vn2d_corner.sv
// One lattice corner: hash -> corner value, five register stages.
module vn2d_corner #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_ix,
    input  logic [31:0]          i_iz,
    input  logic [31:0]          i_seed,
    output logic signed [FRAC_BITS+1:0] o_value
);
    import vn2d_pkg::*;

    localparam int SH = 30 - FRAC_BITS;

    logic [31:0] r_h0;
    logic [31:0] r_h1;
    logic [31:0] r_hh;
    logic [31:0] r_h2;
    logic [31:0] r_p;
    logic [31:0] r_m;
    logic [31:0] n_h0;
    logic [31:0] n_h1;
    logic signed [31:0] n_diff;

    always_comb begin
        n_h0 = i_ix + i_iz * HASH_MUL_Z + i_seed * HASH_MUL_S;
        n_h1 = (r_h0 << 13) ^ r_h0;
        n_diff = 32'sd1073741824 - $signed({1'b0, r_m[30:0]});
    end

    // One full 32-bit product per stage: h*h, then h*(h*h*A + B).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            r_hh <= n_h1 * n_h1;
            r_h2 <= r_h1;
            r_p  <= r_hh * HASH_MUL_A + HASH_ADD_B;
            r_m  <= r_h2 * r_p + HASH_ADD_C;
            o_value <= (FRAC_BITS+2)'(n_diff >>> SH);
        end
    end

endmodule

### rtl/value_noise_2d_smoothstep.sv
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_coord_x, i_coord_z, i_seed
// out     | o_valid | i_stall | o_noise_value
// One point per cycle while not stalled; depth set by the corner hash
// (one 32-bit product per stage) and the two-level weight products.
// Synchronous active-low reset clears the valid bits only.
// A stall on the output freezes the whole pipeline; o_stall = i_stall & o_valid.
module value_noise_2d_smoothstep #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [vn2d_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vn2d_pkg::COORD_W-1:0] i_coord_z,
    input  logic signed [vn2d_pkg::COORD_W-1:0] i_seed,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [vn2d_pkg::OUT_W-1:0]  o_noise_value
);
    import vn2d_pkg::*;

    localparam int LAT = 8;
    localparam int FW  = FRAC_BITS + 2;        // signed fraction / corner width
    // Weights reach 5.0 for negative fractions, a single term 25.0.
    localparam int WW  = FRAC_BITS + 7;
    localparam int PW  = 2 * WW;
    localparam logic signed [WW-1:0] ONE  = WW'(1) <<< FRAC_BITS;
    localparam logic signed [WW-1:0] ONE3 = ONE + ONE + ONE;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Split: truncate toward zero.
    function automatic logic [31:0] int_part(input logic signed [31:0] c);
        logic [31:0] mag;
        mag = c[31] ? (32'd0 - c) : c;
        mag = mag >> FRAC_BITS;
        return c[31] ? (32'd0 - mag) : mag;
    endfunction

    logic [31:0] ix, iz;
    logic signed [FW-1:0] fx, fz;
    always_comb begin
        ix = int_part(i_coord_x);
        iz = int_part(i_coord_z);
        fx = FW'(i_coord_x - $signed(ix << FRAC_BITS));
        fz = FW'(i_coord_z - $signed(iz << FRAC_BITS));
    end

    logic signed [FW-1:0] ca, cb, cc, cd;
    vn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_a (.i_clk, .i_en(en), .i_ix(ix),
        .i_iz(iz), .i_seed(i_seed), .o_value(ca));
    vn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_b (.i_clk, .i_en(en), .i_ix(ix + 32'd1),
        .i_iz(iz), .i_seed(i_seed), .o_value(cb));
    vn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_c (.i_clk, .i_en(en), .i_ix(ix),
        .i_iz(iz + 32'd1), .i_seed(i_seed), .o_value(cc));
    vn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_d (.i_clk, .i_en(en), .i_ix(ix + 32'd1),
        .i_iz(iz + 32'd1), .i_seed(i_seed), .o_value(cd));

    // Smoothstep, stages 1..3; then delayed to line up with corners (stages 4, 5).
    logic signed [FW-1:0] r_fx1, r_fz1, r_fx2, r_fz2;
    logic signed [WW-1:0] r_fx2sq, r_fz2sq, r_u, r_v, r_u4, r_v4, r_u5, r_v5;
    logic signed [WW-1:0] wt_x, wt_z;
    logic signed [PW-1:0] sq_x, sq_z, pu_x, pu_z;
    always_comb begin
        sq_x = r_fx1 * r_fx1;
        sq_z = r_fz1 * r_fz1;
        wt_x = ONE3 - WW'(r_fx2) - WW'(r_fx2);
        wt_z = ONE3 - WW'(r_fz2) - WW'(r_fz2);
        pu_x = r_fx2sq * wt_x;
        pu_z = r_fz2sq * wt_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx1 <= fx;
            r_fz1 <= fz;
            r_fx2 <= r_fx1;
            r_fz2 <= r_fz1;
            r_fx2sq <= WW'(sq_x >>> FRAC_BITS);
            r_fz2sq <= WW'(sq_z >>> FRAC_BITS);
            r_u <= WW'(pu_x >>> FRAC_BITS);
            r_v <= WW'(pu_z >>> FRAC_BITS);
            r_u4 <= r_u;
            r_v4 <= r_v;
            r_u5 <= r_u4;
            r_v5 <= r_v4;
        end
    end

    // Stage 6: corner * x weight; stage 7: * z weight, sum.
    logic signed [WW-1:0] r_ta, r_tb, r_tc, r_td, r_v6;
    logic signed [WW-1:0] wu_0, wv_0;
    logic signed [PW-1:0] pa, pb, pc, pd, qa, qb, qc, qd;
    logic signed [PW-1:0] r_sum;
    always_comb begin
        wu_0 = ONE - r_u5;
        wv_0 = ONE - r_v6;
        pa = ca * wu_0;
        pb = cb * r_u5;
        pc = cc * wu_0;
        pd = cd * r_u5;
        qa = r_ta * wv_0;
        qb = r_tb * wv_0;
        qc = r_tc * r_v6;
        qd = r_td * r_v6;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ta <= WW'(pa >>> FRAC_BITS);
            r_tb <= WW'(pb >>> FRAC_BITS);
            r_tc <= WW'(pc >>> FRAC_BITS);
            r_td <= WW'(pd >>> FRAC_BITS);
            r_v6 <= r_v5;
            r_sum <= (qa >>> FRAC_BITS) + (qb >>> FRAC_BITS)
                   + (qc >>> FRAC_BITS) + (qd >>> FRAC_BITS);
        end
    end

    localparam logic signed [PW-1:0] OMAX = PW'(8388607);
    localparam logic signed [PW-1:0] OMIN = PW'(-8388608);
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_noise_value <= (r_sum > OMAX) ? OUT_W'(OMAX) :
                             (r_sum < OMIN) ? OUT_W'(OMIN) : OUT_W'(r_sum);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_noise_value)) else $error("out lost");
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall) else $error("stall while empty");
    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && $past(i_rst_n) |=> r_vld[0] == $past(i_valid)) else $error("valid");

endmodule

### sim/vn2d_checker.sv
module vn2d_checker #(
    parameter int FRAC_BITS = vn2d_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_z,
    input  logic [31:0] i_seed,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [23:0] i_noise_value,
    output int          o_errors,
    output int          o_pending
);
    import vn2d_pkg::*;

    logic [23:0] noise_q[$];

    function automatic longint floor_div(longint v, int s);
        return v >>> s;  // arithmetic shift floors
    endfunction

    function automatic longint lattice_value(logic [31:0] ix, logic [31:0] iz,
                                             logic [31:0] sd);
        logic [31:0] h;
        logic [31:0] m;
        h = ix + iz * HASH_MUL_Z + sd * HASH_MUL_S;
        h = (h << 13) ^ h;
        m = (h * (h * h * HASH_MUL_A + HASH_ADD_B) + HASH_ADD_C) & 32'h7fffffff;
        return floor_div(longint'(1073741824) - longint'(m), 30 - FRAC_BITS);
    endfunction

    function automatic longint fade(longint f);
        longint one;
        longint f2;
        one = longint'(1) << FRAC_BITS;
        f2 = floor_div(f * f, FRAC_BITS);
        return floor_div(f2 * (3 * one - 2 * f), FRAC_BITS);
    endfunction

    function automatic longint blend(longint c, longint w1, longint w2);
        return floor_div(floor_div(c * w1, FRAC_BITS) * w2, FRAC_BITS);
    endfunction

    function automatic logic [23:0] noise_at(logic [31:0] xr, logic [31:0] zr,
                                             logic [31:0] sd);
        longint one, x, z, ixl, izl, fx, fz, u, v, a, b, c, d, sum;
        logic [31:0] ix, iz;
        one = longint'(1) << FRAC_BITS;
        x = longint'($signed(xr));
        z = longint'($signed(zr));
        // truncate toward zero
        ixl = (x >= 0) ? (x >>> FRAC_BITS) : -((-x) >>> FRAC_BITS);
        izl = (z >= 0) ? (z >>> FRAC_BITS) : -((-z) >>> FRAC_BITS);
        fx = x - ixl * one;
        fz = z - izl * one;
        ix = ixl[31:0];
        iz = izl[31:0];
        a = lattice_value(ix, iz, sd);
        b = lattice_value(ix + 32'd1, iz, sd);
        c = lattice_value(ix, iz + 32'd1, sd);
        d = lattice_value(ix + 32'd1, iz + 32'd1, sd);
        u = fade(fx);
        v = fade(fz);
        sum = blend(a, one - u, one - v) + blend(b, u, one - v)
            + blend(c, one - u, v) + blend(d, u, v);
        if (sum > 8388607) sum = 8388607;
        if (sum < -8388608) sum = -8388608;
        return sum[23:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                noise_q.push_back(noise_at(i_coord_x, i_coord_z, i_seed));
            if (i_out_valid && !i_out_stall) begin
                if (noise_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_noise_value);
                    o_errors <= o_errors + 1;
                end else begin
                    if (noise_q[0] !== i_noise_value) begin
                        $display("%0t: noise_value expected %h actual %h",
                                 $time, noise_q[0], i_noise_value);
                        o_errors <= o_errors + 1;
                    end
                    void'(noise_q.pop_front());
                end
            end
            o_pending <= noise_q.size();
        end
    end
endmodule

### sim/tb.sv
module tb;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] coord_x = 0, coord_z = 0, seed = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [23:0] noise_value;
    int          errors, pending;
    int          cycles = 0;
    bit          hold_off = 0;

    always #5 i_clk = ~i_clk;

    value_noise_2d_smoothstep u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_coord_x(coord_x), .i_coord_z(coord_z), .i_seed(seed),
        .o_valid(out_valid), .i_stall(out_stall), .o_noise_value(noise_value)
    );

    vn2d_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_coord_x(coord_x), .i_coord_z(coord_z), .i_seed(seed),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_noise_value(noise_value), .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'hffffffff;
            3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
            4: return {16'h0000, 16'(($urandom))};
            default: return $urandom;
        endcase
    endfunction

    // one request; waits for acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] z, logic [31:0] s);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 0;
        end
        @(negedge i_clk);
        in_valid <= 1;
        coord_x <= x;
        coord_z <= z;
        seed <= s;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // receiver stall pattern: a drawn wait before each result
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            repeat (w) begin
                @(negedge i_clk);
                out_stall <= 1;
            end
            do begin
                @(negedge i_clk);
                out_stall <= hold_off;
                @(posedge i_clk);
            end while (!(out_valid && !out_stall));
        end
    end

    initial begin
        logic [31:0] ex [0:7];
        ex = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff,
               32'h0000ffff, 32'hffff0001, 32'h00018000, 32'hfffe8000};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < 8; i++)
            send_point(ex[i], ex[7 - i], ex[(i * 3) % 8]);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_point(32'h80000000, 32'h80000000, 32'h7fffffff);
        send_point(32'h00008000, 32'hffff8000, 32'hffffffff);
        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 20; i++) send_point($urandom, $urandom, $urandom);
        join
        for (int i = 0; i < 830; i++)
            send_point(pick_word(), pick_word(), pick_word());
        @(negedge i_clk);
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
